// File: hw/rtl/cddo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cddo_pkg: shared types and calendar helpers
// Date record type, year range constants and the small calendar tables
// (month length, days before a month, days before a year).
// ----------------------------------------------------------------------------
package cddo_pkg;

    localparam int unsigned YEAR_FIRST   = 1900;
    localparam int unsigned YEAR_LAST    = 2099;
    localparam int unsigned YEAR_DEFAULT = 2000;
    localparam int unsigned SERIAL_MAX   = 73049;

    // Years are carried internally as an offset from the first year.
    localparam logic [7:0] YOFS_LAST    = 8'(YEAR_LAST - YEAR_FIRST);
    localparam logic [7:0] YOFS_DEFAULT = 8'(YEAR_DEFAULT - YEAR_FIRST);

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [7:0] yofs;
        logic [3:0] month;
        logic [4:0] day;
    } t_date;

    // Inside the supported range every year divisible by four is a leap year,
    // except the first one; the year 2000 is divisible by 400.
    function automatic logic f_is_leap(input logic [7:0] yofs);
        return (yofs[1:0] == 2'b00) && (yofs != 8'd0);
    endfunction

    function automatic logic [4:0] f_month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] f_year_len(input logic [7:0] yofs);
        return f_is_leap(yofs) ? 9'd366 : 9'd365;
    endfunction

    // Days in the year before the first of month m.
    function automatic logic [8:0] f_month_start(input logic [3:0] m, input logic leap);
        logic [8:0] base;
        case (m)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return (leap && (m > MONTH_FEB)) ? base + 9'd1 : base;
    endfunction

    // Days from the first day of the range to the first day of the year.
    function automatic logic [16:0] f_year_start(input logic [7:0] yofs);
        logic [16:0] base;
        logic [16:0] leaps;
        base  = 17'(yofs) * 17'd365;
        leaps = (yofs == 8'd0) ? 17'd0 : 17'((yofs - 8'd1) >> 2);
        return base + leaps;
    endfunction

endpackage

// File: hw/rtl/cddo_sanitize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cddo_sanitize: date sanitizer
// Replaces an out-of-range year, month or day by its default and returns the
// date with the year as an offset from the first supported year.
// ----------------------------------------------------------------------------
module cddo_sanitize import cddo_pkg::*; (
    input  logic [11:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [5:0]  i_day,
    output t_date       o_date
);

    logic [7:0] w_yofs;
    logic [3:0] w_month;
    logic [4:0] w_len;

    always_comb begin
        if ((i_year < 12'(YEAR_FIRST)) || (i_year > 12'(YEAR_LAST))) begin
            w_yofs = YOFS_DEFAULT;
        end else begin
            w_yofs = 8'(i_year - 12'(YEAR_FIRST));
        end

        if ((i_month == 4'd0) || (i_month > MONTH_DEC)) begin
            w_month = MONTH_JAN;
        end else begin
            w_month = i_month;
        end

        // The day is judged against the already sanitized year and month.
        w_len = f_month_len(w_month, f_is_leap(w_yofs));

        o_date.yofs  = w_yofs;
        o_date.month = w_month;
        if ((i_day == 6'd0) || (i_day > {1'b0, w_len})) begin
            o_date.day = 5'd1;
        end else begin
            o_date.day = i_day[4:0];
        end
    end

endmodule

// File: hw/rtl/calendar_date_day_offset.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_day_offset: Gregorian date offset, serial and compare
// Sanitizes two dates, numbers date A, adds a signed day offset to it and
// converts the result back to a date, and compares A with B.
// ----------------------------------------------------------------------------
// The block takes one input word holding two dates A and B (years 1900 to
// 2099) and a signed day offset, and returns one output word. Out-of-range
// fields are replaced: a year becomes 2000, a month becomes January, and a
// day that does not exist in its month becomes the first. The output gives
// the serial day number of A (1900-01-01 is day 1, 2099-12-31 is day 73049),
// the date lying the offset after A, the difference A minus B in days with
// less and equal flags, and a saturated flag when A plus the offset left the
// supported range, in which case the result is the nearest end of the range.
// After acceptance, seven fixed steps compute both serial numbers, the
// difference, the sum and the clamp, then the conversion back subtracts one
// whole year per cycle (up to 199 years) and one month per cycle (up to 11
// months) before the result is posted. All additions and subtractions of
// day counts run through a single shared 19-bit add/subtract unit. The
// input side is ready only while the sequencer is idle; a finished word
// sits in the output register, so the next input word may be accepted while
// the previous result still waits to be taken.
// ----------------------------------------------------------------------------
module calendar_date_day_offset import cddo_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [11:0]        i_year_a,
    input  logic [3:0]         i_month_a,
    input  logic [5:0]         i_day_a,
    input  logic [11:0]        i_year_b,
    input  logic [3:0]         i_month_b,
    input  logic [5:0]         i_day_b,
    input  logic signed [17:0] i_offset_days,
    // Output channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [11:0]        o_result_year,
    output logic [3:0]         o_result_month,
    output logic [4:0]         o_result_day,
    output logic [16:0]        o_serial_a,
    output logic signed [17:0] o_difference,
    output logic               o_a_less,
    output logic               o_a_equal,
    output logic               o_saturated
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SA1  = 4'd1;   // year start plus month start of A
    localparam logic [3:0] S_SA2  = 4'd2;   // add day of A
    localparam logic [3:0] S_SB1  = 4'd3;   // year start plus month start of B
    localparam logic [3:0] S_SB2  = 4'd4;   // add day of B
    localparam logic [3:0] S_DIF  = 4'd5;   // serial A minus serial B
    localparam logic [3:0] S_OFF  = 4'd6;   // serial A plus offset
    localparam logic [3:0] S_CLMP = 4'd7;   // clamp to the supported range
    localparam logic [3:0] S_YEAR = 4'd8;   // strip whole years
    localparam logic [3:0] S_MON  = 4'd9;   // strip whole months
    localparam logic [3:0] S_DONE = 4'd10;  // post the result

    localparam logic signed [18:0] ACC_MAX = 19'(SERIAL_MAX);
    localparam logic signed [18:0] ACC_MIN = 19'sd1;

    logic [3:0]         r_state, n_state;

    // Sanitized operands, captured on acceptance.
    t_date              w_date_a, w_date_b;
    t_date              r_date_a, r_date_b;
    logic signed [17:0] r_off;

    // Working registers.
    logic signed [18:0] r_acc;
    logic [16:0]        r_sa;
    logic [16:0]        r_sb;
    logic signed [17:0] r_diff;
    logic               r_less;
    logic               r_equal;
    logic               r_sat;
    logic [7:0]         r_yr;
    logic [3:0]         r_mo;

    // Output register.
    logic               r_out_valid;
    logic [11:0]        r_out_year;
    logic [3:0]         r_out_month;
    logic [4:0]         r_out_day;
    logic [16:0]        r_out_serial;
    logic signed [17:0] r_out_diff;
    logic               r_out_less;
    logic               r_out_equal;
    logic               r_out_sat;

    // Shared add/subtract unit.
    logic signed [18:0] w_op_a, w_op_b, w_sum;
    logic               w_sub;
    logic               w_sum_pos;

    logic               w_accept;
    logic               w_post;

    cddo_sanitize u_san_a (
        .i_year  (i_year_a),
        .i_month (i_month_a),
        .i_day   (i_day_a),
        .o_date  (w_date_a)
    );

    cddo_sanitize u_san_b (
        .i_year  (i_year_b),
        .i_month (i_month_b),
        .i_day   (i_day_b),
        .o_date  (w_date_b)
    );

    // No word is taken while reset is held.
    assign o_ready  = i_rst_n && (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    // A result moves to the output register once that register is free.
    assign w_post   = (r_state == S_DONE) && (!r_out_valid || i_ready);

    // Operand selection for the shared unit.
    always_comb begin
        w_op_a = r_acc;
        w_op_b = '0;
        w_sub  = 1'b0;
        case (r_state)
            S_SA1: begin
                w_op_a = 19'(f_year_start(r_date_a.yofs));
                w_op_b = 19'(f_month_start(r_date_a.month, f_is_leap(r_date_a.yofs)));
            end
            S_SA2: begin
                w_op_b = 19'(r_date_a.day);
            end
            S_SB1: begin
                w_op_a = 19'(f_year_start(r_date_b.yofs));
                w_op_b = 19'(f_month_start(r_date_b.month, f_is_leap(r_date_b.yofs)));
            end
            S_SB2: begin
                w_op_b = 19'(r_date_b.day);
            end
            S_DIF: begin
                w_op_a = 19'(r_sa);
                w_op_b = 19'(r_sb);
                w_sub  = 1'b1;
            end
            S_OFF: begin
                w_op_a = 19'(r_sa);
                w_op_b = {r_off[17], r_off};
            end
            S_YEAR: begin
                w_op_b = 19'(f_year_len(r_yr));
                w_sub  = 1'b1;
            end
            S_MON: begin
                w_op_b = 19'(f_month_len(r_mo, f_is_leap(r_yr)));
                w_sub  = 1'b1;
            end
            default: begin
                w_op_b = '0;
            end
        endcase
    end

    assign w_sum     = w_sub ? (w_op_a - w_op_b) : (w_op_a + w_op_b);
    assign w_sum_pos = !w_sum[18] && (w_sum != 19'sd0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SA1;
                end
            end
            S_SA1:  n_state = S_SA2;
            S_SA2:  n_state = S_SB1;
            S_SB1:  n_state = S_SB2;
            S_SB2:  n_state = S_DIF;
            S_DIF:  n_state = S_OFF;
            S_OFF:  n_state = S_CLMP;
            S_CLMP: n_state = S_YEAR;
            S_YEAR: begin
                if (!(w_sum_pos && (r_yr < YOFS_LAST))) begin
                    n_state = S_MON;
                end
            end
            S_MON: begin
                if (!(w_sum_pos && (r_mo < MONTH_DEC))) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_post) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_post) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_date_a <= w_date_a;
            r_date_b <= w_date_b;
            r_off    <= i_offset_days;
        end

        case (r_state)
            S_SA1, S_SB1: begin
                r_acc <= w_sum;
            end
            S_SA2: begin
                r_sa <= w_sum[16:0];
            end
            S_SB2: begin
                r_sb <= w_sum[16:0];
            end
            S_DIF: begin
                r_diff  <= w_sum[17:0];
                r_less  <= w_sum[18];
                r_equal <= (w_sum == 19'sd0);
            end
            S_OFF: begin
                r_acc <= w_sum;
            end
            S_CLMP: begin
                r_yr <= 8'd0;
                r_mo <= MONTH_JAN;
                if (r_acc < ACC_MIN) begin
                    r_acc <= ACC_MIN;
                    r_sat <= 1'b1;
                end else if (r_acc > ACC_MAX) begin
                    r_acc <= ACC_MAX;
                    r_sat <= 1'b1;
                end else begin
                    r_sat <= 1'b0;
                end
            end
            S_YEAR: begin
                if (w_sum_pos && (r_yr < YOFS_LAST)) begin
                    r_acc <= w_sum;
                    r_yr  <= r_yr + 8'd1;
                end
            end
            S_MON: begin
                if (w_sum_pos && (r_mo < MONTH_DEC)) begin
                    r_acc <= w_sum;
                    r_mo  <= r_mo + 4'd1;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase

        if (w_post) begin
            r_out_year   <= 12'(YEAR_FIRST) + 12'(r_yr);
            r_out_month  <= r_mo;
            r_out_day    <= r_acc[4:0];
            r_out_serial <= r_sa;
            r_out_diff   <= r_diff;
            r_out_less   <= r_less;
            r_out_equal  <= r_equal;
            r_out_sat    <= r_sat;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_year  = r_out_year;
    assign o_result_month = r_out_month;
    assign o_result_day   = r_out_day;
    assign o_serial_a     = r_out_serial;
    assign o_difference   = r_out_diff;
    assign o_a_less       = r_out_less;
    assign o_a_equal      = r_out_equal;
    assign o_saturated    = r_out_sat;

    // The result year and month lie inside the supported range and the day is not zero.
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result_year >= 12'(YEAR_FIRST)) && (o_result_year <= 12'(YEAR_LAST))
                    && (o_result_month >= MONTH_JAN) && (o_result_month <= MONTH_DEC)
                    && (o_result_day != 5'd0))
        else $error("result date out of range");

    // Compare flags agree with the difference.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_a_less && o_a_equal) && (o_a_equal == (o_difference == 18'sd0))
                    && (o_a_less == o_difference[17]))
        else $error("compare flags disagree with difference");

    // A clamped result is one of the two ends of the range.
    a_sat_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            ((o_result_year == 12'(YEAR_FIRST)) && (o_result_month == MONTH_JAN)
             && (o_result_day == 5'd1))
            || ((o_result_year == 12'(YEAR_LAST)) && (o_result_month == MONTH_DEC)
             && (o_result_day == 5'd31)))
        else $error("saturated result is not a range end");

    // Accepting a word starts the sequencer, which then is busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted while sequencer busy");

endmodule
